### design/cfh_pkg.sv
// Shared types, constants and helpers for the command frame handler.
`timescale 1ns / 1ps
package cfh_pkg;

    localparam int CHANNELS   = 3;
    localparam int WORDS      = 3 * CHANNELS;
    localparam int FRAME_LEN  = 12 * CHANNELS + 3;
    localparam int SHORT_LEN  = 3;
    localparam int STATUS_LEN = 3;
    localparam int CAP_LEN    = 19;
    localparam int CNT_W      = $clog2(FRAME_LEN + 1);
    localparam int RIDX_W     = $clog2(CAP_LEN + 1);
    localparam int WIDX_W     = $clog2(WORDS);
    localparam int REC_BITS   = 32 * WORDS;

    localparam logic [31:0] MIN_PERIOD  = 32'd3;
    localparam logic [31:0] MAX_PERIOD  = 32'hFFFF_FFFF;
    localparam logic [31:0] TICK_UNIT   = 32'd1;
    localparam logic [31:0] TPS_RESET   = 32'd200_000_000;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;

    localparam logic [7:0] CMD_LOAD    = 8'd1;
    localparam logic [7:0] CMD_SAVE    = 8'd2;
    localparam logic [7:0] CMD_RESTORE = 8'd3;
    localparam logic [7:0] CMD_CAPS    = 8'd4;

    localparam logic [7:0] ST_OK        = 8'd0;
    localparam logic [7:0] ST_BAD_CMD   = 8'd1;
    localparam logic [7:0] ST_BAD_SAVED = 8'd2;
    localparam logic [7:0] CAP_ID       = 8'h04;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PARSE,
        S_CRC_IN,
        S_CHECK,
        S_REPLY_LOAD,
        S_REPLY_CRC,
        S_REPLY_OUT
    } state_t;

    typedef struct packed {
        logic load;   // xor a byte into the register
        logic init;   // start from the init value on load
        logic step;   // one shift of the LFSR
    } crc_ctl_t;

    // Capability reply byte at position idx (CRC bytes excluded)
    function automatic logic [7:0] cap_byte(input logic [RIDX_W-1:0] idx,
                                            input logic [31:0] tps);
        logic [RIDX_W-1:0] k;
        logic [31:0]       w;
        logic [31:0]       sh;
        k = idx - RIDX_W'(1);
        case (k[4:2])
            3'd0:    w = MIN_PERIOD;
            3'd1:    w = MAX_PERIOD;
            3'd2:    w = TICK_UNIT;
            default: w = tps;
        endcase
        sh = w >> {~k[1:0], 3'b000};
        if (idx == '0) begin
            return CAP_ID;
        end
        return sh[7:0];
    endfunction

endpackage

### design/cfh_crc16.sv
// Bit-serial CRC16/MODBUS register shared by frame check and reply generation.
`timescale 1ns / 1ps
module cfh_crc16 import cfh_pkg::*; (
    input  logic       aclk,
    input  crc_ctl_t   ctl,
    input  logic [7:0] data,
    output logic [15:0] crc
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;

    always_comb begin
        crc_next = crc_reg;
        if (ctl.load) begin
            crc_next = (ctl.init ? CRC_INIT : crc_reg) ^ {8'h00, data};
        end else if (ctl.step) begin
            crc_next = crc_reg[0] ? ((crc_reg >> 1) ^ CRC_POLY) : (crc_reg >> 1);
        end
    end

    always_ff @(posedge aclk) begin
        crc_reg <= crc_next;
    end

    assign crc = crc_reg;

endmodule

### design/crc_checked_command_frame_handler.sv
// Top level: command frame assembly, CRC check, range check and reply sequencer.
//
//  channel | dir | beat content
//  s_axis  | in  | tdata[7:0] rx_byte
//  m_axis  | out | tdata[7:0] tx_byte, [8] settings_applied, [11:9] channel_enable; tlast
//  cfg     | in  | cfg_wr_data = clock rate reported in the capability reply
//
// Each received byte passes through idle and parse, plus 8 CRC shift steps when it enters the CRC.
// A completed frame runs a range check of one word per cycle (up to 9 words),
// then each reply data byte passes through load, 8 CRC steps and output, and each
// CRC byte through load and output, plus output wait.
// Reset (synchronous, active low) clears frame count, active record, enables and saved flag.
// s_axis_tready is high only while idle; m_axis stalls hold the reply.
`timescale 1ns / 1ps
module crc_checked_command_frame_handler import cfh_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] tx_byte, [8] settings_applied,
                                        // [11:9] channel_enable, [15:12] zero
    output logic        m_axis_tlast,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data
);

    state_t state_reg, state_next;

    logic [31:0]             tps_reg;
    logic [7:0]              byte_reg;
    logic [7:0]              pv_reg;
    logic [7:0]              cmd_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [REC_BITS-1:0]     rec_reg;
    logic [WORDS-1:0][31:0]  active_reg;
    logic [WORDS-1:0][31:0]  saved_reg;
    logic                    saved_valid_reg;
    logic [CHANNELS-1:0]     mask_reg;
    logic [CHANNELS-1:0]     m_reg;
    logic [WIDX_W-1:0]       w_reg;
    logic [1:0]              ph_reg;
    logic [1:0]              ch_reg;
    logic                    src_sel_reg;
    logic [2:0]              bit_reg;
    logic [RIDX_W-1:0]       ridx_reg;
    logic                    cap_reg;
    logic                    applied_reg;
    logic [7:0]              code_reg;
    logic [7:0]              tx_reg;

    crc_ctl_t    crc_ctl;
    logic [7:0]  crc_data;
    logic [15:0] crc_val;

    cfh_crc16 u_crc (
        .aclk (aclk),
        .ctl  (crc_ctl),
        .data (crc_data),
        .crc  (crc_val)
    );

    // frame decode
    logic [7:0]       cmd_w;
    logic             cmd_ok;
    logic [CNT_W-1:0] need;
    logic             feed;
    logic             last;
    logic             crc_good;
    logic             rec_shift;

    assign cmd_w    = (cnt_reg == '0) ? byte_reg : cmd_reg;
    assign cmd_ok   = (cmd_w == CMD_LOAD) || (cmd_w == CMD_SAVE) ||
                      (cmd_w == CMD_RESTORE) || (cmd_w == CMD_CAPS);
    assign need     = (cmd_w == CMD_LOAD) ? CNT_W'(FRAME_LEN) : CNT_W'(SHORT_LEN);
    assign feed     = cnt_reg < (need - CNT_W'(2));
    assign last     = (cnt_reg + CNT_W'(1)) == need;
    assign crc_good = {pv_reg, byte_reg} == crc_val;
    assign rec_shift = (cmd_w == CMD_LOAD) && (cnt_reg != '0) &&
                       (cnt_reg <= CNT_W'(4 * WORDS));

    // range check on one word per cycle
    logic [31:0]         src_word;
    logic                chk_fail;
    logic [CHANNELS-1:0] m_with;
    logic [WORDS-1:0][31:0] rec_words;

    always_comb begin
        for (int i = 0; i < WORDS; i++) begin
            rec_words[i] = rec_reg[REC_BITS-1-32*i -: 32];
        end
    end

    assign src_word = src_sel_reg ? saved_reg[w_reg] : rec_words[w_reg];
    assign chk_fail = ((ph_reg != 2'd1) || (src_word != '0)) && (src_word < MIN_PERIOD);
    always_comb begin
        m_with = m_reg;
        if ((ph_reg == 2'd1) && (src_word != '0)) begin
            m_with[ch_reg] = 1'b1;
        end
    end

    // reply byte selection
    logic [RIDX_W-1:0] rlen;
    logic              is_crc_byte;
    logic [7:0]        byte_val;
    logic              out_last;

    assign rlen        = cap_reg ? RIDX_W'(CAP_LEN) : RIDX_W'(STATUS_LEN);
    assign is_crc_byte = ridx_reg >= (rlen - RIDX_W'(2));
    assign out_last    = ridx_reg == (rlen - RIDX_W'(1));
    always_comb begin
        if (is_crc_byte) begin
            byte_val = (ridx_reg == (rlen - RIDX_W'(2))) ? crc_val[15:8] : crc_val[7:0];
        end else if (cap_reg) begin
            byte_val = cap_byte(ridx_reg, tps_reg);
        end else begin
            byte_val = code_reg;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid) state_next = S_PARSE;
            end
            S_PARSE: begin
                if (!cmd_ok) begin
                    state_next = S_IDLE;
                end else if (feed) begin
                    state_next = S_CRC_IN;
                end else if (!last) begin
                    state_next = S_IDLE;
                end else if (!crc_good) begin
                    state_next = S_REPLY_LOAD;
                end else if ((cmd_w == CMD_LOAD) ||
                             ((cmd_w == CMD_RESTORE) && saved_valid_reg)) begin
                    state_next = S_CHECK;
                end else begin
                    state_next = S_REPLY_LOAD;
                end
            end
            S_CRC_IN: begin
                if (bit_reg == 3'd7) state_next = S_IDLE;
            end
            S_CHECK: begin
                if (chk_fail || (w_reg == WIDX_W'(WORDS - 1))) state_next = S_REPLY_LOAD;
            end
            S_REPLY_LOAD: begin
                state_next = is_crc_byte ? S_REPLY_OUT : S_REPLY_CRC;
            end
            S_REPLY_CRC: begin
                if (bit_reg == 3'd7) state_next = S_REPLY_OUT;
            end
            S_REPLY_OUT: begin
                if (m_axis_tready) state_next = out_last ? S_IDLE : S_REPLY_LOAD;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs and CRC control
    always_comb begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        crc_ctl       = '0;
        crc_data      = byte_reg;
        case (state_reg)
            S_IDLE: s_axis_tready = 1'b1;
            S_PARSE: begin
                crc_ctl.load = cmd_ok && feed;
                crc_ctl.init = cnt_reg == '0;
            end
            S_CRC_IN:    crc_ctl.step = 1'b1;
            S_REPLY_LOAD: begin
                crc_data     = byte_val;
                crc_ctl.load = !is_crc_byte;
                crc_ctl.init = ridx_reg == '0;
            end
            S_REPLY_CRC: crc_ctl.step = 1'b1;
            S_REPLY_OUT: m_axis_tvalid = 1'b1;
            default: ;
        endcase
    end

    assign m_axis_tdata = {4'b0000, mask_reg, applied_reg, tx_reg};
    assign m_axis_tlast = out_last;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            tps_reg         <= TPS_RESET;
            cnt_reg         <= '0;
            saved_valid_reg <= 1'b0;
            mask_reg        <= '0;
            active_reg      <= '0;
            bit_reg         <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) tps_reg <= cfg_wr_data;
            bit_reg <= ((state_reg == S_CRC_IN) || (state_reg == S_REPLY_CRC)) ?
                       bit_reg + 3'd1 : 3'd0;
            if (state_reg == S_PARSE) begin
                cnt_reg <= (!cmd_ok || last) ? '0 : cnt_reg + CNT_W'(1);
                if (cmd_ok && last && crc_good && (cmd_w == CMD_SAVE)) begin
                    saved_valid_reg <= 1'b1;
                end
            end
            if (state_reg == S_CHECK) begin
                if (chk_fail) begin
                    mask_reg <= '0;
                end else if (w_reg == WIDX_W'(WORDS - 1)) begin
                    mask_reg   <= m_with;
                    active_reg <= src_sel_reg ? saved_reg : rec_words;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if ((state_reg == S_IDLE) && s_axis_tvalid) begin
            byte_reg <= s_axis_tdata;
        end
        case (state_reg)
            S_PARSE: begin
                pv_reg <= byte_reg;
                if (cnt_reg == '0) cmd_reg <= byte_reg;
                if (rec_shift) rec_reg <= {rec_reg[REC_BITS-9:0], byte_reg};
                ridx_reg    <= '0;
                cap_reg     <= crc_good && (cmd_w == CMD_CAPS);
                applied_reg <= 1'b0;
                code_reg    <= !crc_good ? ST_BAD_CMD :
                               ((cmd_w == CMD_RESTORE) && !saved_valid_reg) ?
                               ST_BAD_SAVED : ST_OK;
                w_reg       <= '0;
                ph_reg      <= '0;
                ch_reg      <= '0;
                m_reg       <= '0;
                src_sel_reg <= cmd_w == CMD_RESTORE;
                if (cmd_ok && last && crc_good && (cmd_w == CMD_SAVE)) begin
                    saved_reg <= active_reg;
                end
            end
            S_CHECK: begin
                m_reg <= m_with;
                w_reg <= w_reg + WIDX_W'(1);
                if (ph_reg == 2'd2) begin
                    ph_reg <= '0;
                    ch_reg <= ch_reg + 2'd1;
                end else begin
                    ph_reg <= ph_reg + 2'd1;
                end
                if (chk_fail) begin
                    code_reg <= ST_BAD_CMD;
                end else if (w_reg == WIDX_W'(WORDS - 1)) begin
                    code_reg    <= ST_OK;
                    applied_reg <= 1'b1;
                end
            end
            S_REPLY_LOAD: tx_reg <= byte_val;
            S_REPLY_OUT: begin
                if (m_axis_tready) ridx_reg <= ridx_reg + RIDX_W'(1);
            end
            default: ;
        endcase
    end

    // assertions
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while a reply beat is pending");

    a_reply_end_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("not idle after final reply beat");

    a_mask_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |=> $stable(mask_reg))
        else $error("enable mask changed while idle");

    a_crc_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_REPLY_CRC && bit_reg == 3'd7) |=> m_axis_tvalid)
        else $error("reply byte not presented after CRC steps");

endmodule

### verif/tb_crc_checked_command_frame_handler.sv
// Testbench for the CRC-checked command frame handler: directed frames, then random traffic.
`timescale 1ns / 1ps
module tb_crc_checked_command_frame_handler;
    import cfh_pkg::*;

    localparam int WD_LIMIT    = 3000;
    localparam int SETTLE_CYC  = 60;
    localparam int RAND_BYTES  = 160;

    // word-pattern kinds for directed load records
    typedef enum int {
        REC_MIN, REC_MAX, REC_MUTE, REC_DLY_LOW, REC_ON_LOW, REC_OFF_LOW, REC_RAND
    } rec_kind_t;

    typedef struct {
        logic [7:0] cmd;
        rec_kind_t  kind;
        bit         bad_crc;
        int         want;     // expected status byte, -1 when left to the predictor
    } dir_row_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       applied;
        logic [2:0] enables;
    } reply_beat_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;    // [7:0] tx_byte, [8] settings_applied, [11:9] channel_enable
    logic        m_axis_tlast;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;

    crc_checked_command_frame_handler u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // shadow of the handler state
    logic [7:0]  rx_frame [FRAME_LEN];
    int          rx_count;
    logic [31:0] live_rec [WORDS];
    logic [31:0] stored_rec [WORDS];
    bit          stored_ok;
    logic [2:0]  run_mask;
    logic [31:0] tick_rate;

    reply_beat_t reply_q [$];
    int          last_status;
    int          errors;
    int          beats_seen;
    int          bytes_sent;
    int          frames_sent;
    int          idle_pct;
    int          stall_pct;
    int          quiet_cycles;

    function automatic logic [15:0] crc16_modbus(input logic [7:0] buf_q [$]);
        logic [15:0] c;
        c = CRC_INIT;
        foreach (buf_q[i]) begin
            c ^= {8'h00, buf_q[i]};
            for (int k = 0; k < 8; k++)
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic void queue_reply(input logic [7:0] body [$], input bit applied);
        logic [15:0] c;
        reply_beat_t bt;
        c = crc16_modbus(body);
        body.push_back(c[15:8]);
        body.push_back(c[7:0]);
        last_status = body[0];
        foreach (body[i]) begin
            bt.data    = body[i];
            bt.last    = (i == body.size() - 1);
            bt.applied = applied;
            bt.enables = run_mask;
            reply_q.push_back(bt);
        end
    endfunction

    function automatic void queue_status(input logic [7:0] code, input bit applied);
        logic [7:0] body [$];
        body.push_back(code);
        queue_reply(body, applied);
    endfunction

    // range check; on failure all channels stop
    function automatic bit apply_record(input logic [31:0] rec [WORDS]);
        logic [2:0] m;
        m = '0;
        run_mask = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            if (rec[3*c] < MIN_PERIOD || (rec[3*c+1] != 0 && rec[3*c+1] < MIN_PERIOD)
                || rec[3*c+2] < MIN_PERIOD)
                return 0;
            if (rec[3*c+1] != 0)
                m[c] = 1'b1;
        end
        run_mask = m;
        return 1;
    endfunction

    function automatic void take_rx_byte(input logic [7:0] b);
        logic [7:0]  cmd;
        int          need;
        logic [7:0]  body [$];
        logic [31:0] rec [WORDS];
        if (rx_count >= FRAME_LEN)
            rx_count = 0;
        rx_frame[rx_count] = b;
        rx_count++;
        cmd = rx_frame[0];
        if (cmd == CMD_LOAD)
            need = FRAME_LEN;
        else if (cmd == CMD_SAVE || cmd == CMD_RESTORE || cmd == CMD_CAPS)
            need = SHORT_LEN;
        else begin
            rx_count = 0;
            return;
        end
        if (rx_count < need)
            return;
        rx_count = 0;
        for (int i = 0; i < need - 2; i++)
            body.push_back(rx_frame[i]);
        if (crc16_modbus(body) != {rx_frame[need-2], rx_frame[need-1]}) begin
            queue_status(ST_BAD_CMD, 1'b0);
            return;
        end
        body.delete();
        case (cmd)
            CMD_LOAD: begin
                for (int w = 0; w < WORDS; w++)
                    rec[w] = {rx_frame[1+4*w], rx_frame[2+4*w], rx_frame[3+4*w],
                              rx_frame[4+4*w]};
                if (!apply_record(rec)) begin
                    queue_status(ST_BAD_CMD, 1'b0);
                end else begin
                    live_rec = rec;
                    queue_status(ST_OK, 1'b1);
                end
            end
            CMD_SAVE: begin
                stored_rec = live_rec;
                stored_ok  = 1'b1;
                queue_status(ST_OK, 1'b0);
            end
            CMD_RESTORE: begin
                if (!stored_ok)
                    queue_status(ST_BAD_SAVED, 1'b0);
                else if (!apply_record(stored_rec))
                    queue_status(ST_BAD_CMD, 1'b0);
                else begin
                    live_rec = stored_rec;
                    queue_status(ST_OK, 1'b1);
                end
            end
            default: begin
                body.push_back(CAP_ID);
                for (int s = 24; s >= 0; s -= 8) body.push_back(8'(MIN_PERIOD >> s));
                for (int s = 24; s >= 0; s -= 8) body.push_back(8'(MAX_PERIOD >> s));
                for (int s = 24; s >= 0; s -= 8) body.push_back(8'(TICK_UNIT >> s));
                for (int s = 24; s >= 0; s -= 8) body.push_back(8'(tick_rate >> s));
                queue_reply(body, 1'b0);
            end
        endcase
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch @%0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge aclk); while (!s_axis_tready);
        take_rx_byte(b);
        bytes_sent++;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0:       return $urandom_range(5);
            1:       return MAX_PERIOD - $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_frame(input logic [7:0] cmd, input logic [31:0] rec [WORDS],
                              input bit bad_crc);
        logic [7:0]  body [$];
        logic [15:0] c;
        body.push_back(cmd);
        if (cmd == CMD_LOAD)
            foreach (rec[w])
                for (int s = 24; s >= 0; s -= 8) body.push_back(8'(rec[w] >> s));
        c = crc16_modbus(body);
        if (bad_crc)
            c ^= 16'(1 << $urandom_range(15));
        body.push_back(c[15:8]);
        body.push_back(c[7:0]);
        foreach (body[i]) send_byte(body[i]);
        frames_sent++;
    endtask

    task automatic drain_and_set_rate(input logic [31:0] v);
        s_axis_tvalid <= 1'b0;
        while (reply_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        tick_rate = v;
        cfg_wr_en <= 1'b0;
    endtask

    // result side: random stalls and checking
    always @(posedge aclk) begin
        reply_beat_t exp_b;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            beats_seen++;
            if (reply_q.size() == 0) begin
                report("unexpected beat", 32'(m_axis_tdata), 32'd0);
            end else begin
                exp_b = reply_q.pop_front();
                if (m_axis_tdata[7:0] != exp_b.data)
                    report("tx_byte", 32'(m_axis_tdata[7:0]), 32'(exp_b.data));
                if (m_axis_tlast != exp_b.last)
                    report("tlast", 32'(m_axis_tlast), 32'(exp_b.last));
                if (m_axis_tdata[8] != exp_b.applied)
                    report("settings_applied", 32'(m_axis_tdata[8]), 32'(exp_b.applied));
                if (m_axis_tdata[11:9] != exp_b.enables)
                    report("channel_enable", 32'(m_axis_tdata[11:9]), 32'(exp_b.enables));
            end
        end
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // stops a hung run
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", WD_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    dir_row_t dir_rows [18] = '{
        '{CMD_RESTORE, REC_RAND,    1'b0, ST_BAD_SAVED}, // restore, nothing saved
        '{CMD_CAPS,    REC_RAND,    1'b0, -1},
        '{CMD_SAVE,    REC_RAND,    1'b0, ST_OK},        // saves the zero record
        '{CMD_RESTORE, REC_RAND,    1'b0, ST_BAD_CMD},   // zero record fails range check
        '{CMD_LOAD,    REC_MIN,     1'b0, ST_OK},
        '{CMD_LOAD,    REC_MUTE,    1'b0, ST_OK},
        '{CMD_SAVE,    REC_RAND,    1'b0, ST_OK},
        '{CMD_LOAD,    REC_MAX,     1'b0, ST_OK},
        '{CMD_LOAD,    REC_DLY_LOW, 1'b0, ST_BAD_CMD},
        '{CMD_LOAD,    REC_ON_LOW,  1'b0, ST_BAD_CMD},
        '{CMD_LOAD,    REC_OFF_LOW, 1'b0, ST_BAD_CMD},
        '{CMD_RESTORE, REC_RAND,    1'b0, ST_OK},
        '{CMD_LOAD,    REC_RAND,    1'b1, ST_BAD_CMD},   // corrupted CRC
        '{CMD_CAPS,    REC_RAND,    1'b1, ST_BAD_CMD},
        '{8'h00,       REC_RAND,    1'b0, -1},           // unknown command bytes
        '{8'hFF,       REC_RAND,    1'b0, -1},
        '{8'h05,       REC_RAND,    1'b0, -1},
        '{CMD_CAPS,    REC_RAND,    1'b0, -1}
    };

    initial begin
        logic [31:0] rec [WORDS];
        logic [31:0] rates [6];
        int          pick;
        int          base_bytes;
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        rx_count = 0;
        run_mask = '0;
        stored_ok = 0;
        tick_rate = TPS_RESET;
        foreach (live_rec[i]) live_rec[i] = '0;
        errors = 0; beats_seen = 0; bytes_sent = 0; frames_sent = 0; quiet_cycles = 0;
        idle_pct = 0; stall_pct = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        rates = '{32'd0, MAX_PERIOD, 32'd1, 32'd50_000_000, 32'h8000_0000, 32'h0};
        rates[5] = $urandom;
        drain_and_set_rate(32'hA5C3_5A3C);

        foreach (dir_rows[r]) begin
            for (int w = 0; w < WORDS; w++) begin
                case (dir_rows[r].kind)
                    REC_MIN:  rec[w] = MIN_PERIOD;
                    REC_MAX:  rec[w] = MAX_PERIOD;
                    REC_MUTE: rec[w] = (w % 3 == 1 && w != 4) ? 32'd0 : MIN_PERIOD + w;
                    default:  rec[w] = 32'd3 + $urandom_range(1000);
                endcase
            end
            if (dir_rows[r].kind == REC_DLY_LOW) rec[3] = 32'd2;
            if (dir_rows[r].kind == REC_ON_LOW)  rec[7] = 32'd1;
            if (dir_rows[r].kind == REC_OFF_LOW) rec[8] = 32'd2;
            last_status = -1;
            if (dir_rows[r].cmd inside {CMD_LOAD, CMD_SAVE, CMD_RESTORE, CMD_CAPS})
                send_frame(dir_rows[r].cmd, rec, dir_rows[r].bad_crc);
            else
                send_byte(dir_rows[r].cmd);
            if (dir_rows[r].want >= 0 && last_status != dir_rows[r].want)
                report($sformatf("directed row %0d status", r), last_status, dir_rows[r].want);
        end
        base_bytes = bytes_sent;

        // random part over idle/stall phases, each ending drained with a new rate
        for (int ph = 0; ph < 6; ph++) begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 58; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 58; end
                default: begin idle_pct = 29; stall_pct = 29; end
            endcase
            while (bytes_sent < base_bytes + (ph + 1) * RAND_BYTES / 6) begin
                pick = $urandom_range(99);
                foreach (rec[w]) rec[w] = (pick < 45) ? 32'd3 + $urandom_range(100000)
                                                      : rand_word();
                if (pick < 45 && $urandom_range(2) == 0) rec[3*$urandom_range(2)+1] = 0;
                if (pick < 65)      send_frame(CMD_LOAD, rec, 1'b0);
                else if (pick < 72) send_frame(CMD_SAVE, rec, 1'b0);
                else if (pick < 80) send_frame(CMD_RESTORE, rec, 1'b0);
                else if (pick < 86) send_frame(CMD_CAPS, rec, 1'b0);
                else if (pick < 92) send_frame(8'($urandom_range(1, 4)), rec, 1'b1);
                else
                    repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
            end
            drain_and_set_rate(rates[ph]);
        end

        s_axis_tvalid <= 1'b0;
        while (reply_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
        $display("covered %0d frames in %0d bytes, %0d reply beats checked, %0d rates",
                 frames_sent, bytes_sent, beats_seen, 7);
        $display("load/save/restore/caps, range and CRC errors, noise bytes, idle/stall mixes");
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", errors);
            $display("status: fail");
        end
        $finish;
    end

endmodule

### filelist.f
design/cfh_pkg.sv
design/cfh_crc16.sv
design/crc_checked_command_frame_handler.sv
verif/tb_crc_checked_command_frame_handler.sv
